// ===== rtl/core/proof_frame_parser_assert.svh =====
// ----------------------------------------------------------------------------
// Proof frame parser assertion macros
// Concurrent checks on clk_i; they compile away under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef PROOF_FRAME_PARSER_ASSERT_SVH
`define PROOF_FRAME_PARSER_ASSERT_SVH

`ifndef SYNTHESIS
// check that is switched off while reset is asserted
`define PFP_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("%m: check failed");
// check that also runs while reset is asserted
`define PFP_ASSERT_NR(label, prop) \
  label: assert property (@(posedge clk_i) (prop)) \
    else $error("%m: check failed");
`else
`define PFP_ASSERT(label, prop)
`define PFP_ASSERT_NR(label, prop)
`endif

`endif

// ===== rtl/core/pfp_pkg.sv =====
// ----------------------------------------------------------------------------
// Proof frame parser package
// Item types, field tags, error codes and frame layout constants.
// ----------------------------------------------------------------------------
package pfp_pkg;

  // frame layout
  localparam logic [15:0] TENANT_LIMIT   = 16'd64;
  localparam logic [15:0] PROVIDER_LIMIT = 16'd64;
  localparam int unsigned PATH_DEPTH     = 256;
  localparam int unsigned HASH_BYTES     = 32;
  localparam int unsigned PATH_BYTES     = PATH_DEPTH * HASH_BYTES;
  localparam int unsigned CNT_W          = $clog2(PATH_BYTES);

  // queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // field tags
  localparam logic [2:0] KIND_NONE     = 3'd0;
  localparam logic [2:0] KIND_CKPT     = 3'd1;
  localparam logic [2:0] KIND_TENANT   = 3'd2;
  localparam logic [2:0] KIND_PROVIDER = 3'd3;
  localparam logic [2:0] KIND_SEQ      = 3'd4;
  localparam logic [2:0] KIND_HEAD     = 3'd5;
  localparam logic [2:0] KIND_PATH     = 3'd6;

  // error codes
  localparam logic [3:0] ERR_NONE          = 4'd0;
  localparam logic [3:0] ERR_TRUNCATED     = 4'd1;
  localparam logic [3:0] ERR_MAGIC         = 4'd2;
  localparam logic [3:0] ERR_VERSION       = 4'd3;
  localparam logic [3:0] ERR_TENANT_LEN    = 4'd4;
  localparam logic [3:0] ERR_TENANT_ZERO   = 4'd5;
  localparam logic [3:0] ERR_PROVIDER_LEN  = 4'd6;
  localparam logic [3:0] ERR_PROVIDER_ZERO = 4'd7;
  localparam logic [3:0] ERR_TOO_LONG      = 4'd8;
  localparam logic [3:0] ERR_SEQ_ZERO      = 4'd9;

  // input item
  typedef struct packed {
    logic [7:0] wire_byte;
    logic       end_of_frame;
  } pfp_in_t;

  // result item
  typedef struct packed {
    logic [2:0]  field_kind;
    logic [7:0]  byte_value;
    logic [63:0] word_value;
    logic        frame_done;
    logic        frame_ok;
    logic [3:0]  error_code;
  } pfp_out_t;

  // classified byte passed from front to back
  typedef struct packed {
    logic [7:0] wire_byte;
    logic [2:0] kind;
    logic       shift;
    logic       eof;
    logic [3:0] err;
  } pfp_tok_t;

  // 8-byte frame magic "AIMWPRF1"
  function automatic logic [7:0] magic_byte(input logic [2:0] idx);
    logic [7:0] val;
    unique case (idx)
      3'd0: val = 8'h41;
      3'd1: val = 8'h49;
      3'd2: val = 8'h4D;
      3'd3: val = 8'h57;
      3'd4: val = 8'h50;
      3'd5: val = 8'h52;
      3'd6: val = 8'h46;
      3'd7: val = 8'h31;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

// ===== rtl/core/proof_frame_parser.sv =====
// ----------------------------------------------------------------------------
// Proof frame parser: byte-serial frame checker with one result per byte
// Path: each byte is written into the queue and then into the output register, where its result is offered.
// Throughput: one byte per cycle while the queue is not full, set by the combinational front-end phase walk.
// Reset: asynchronous, active low; the parser restarts at the frame magic.
// ----------------------------------------------------------------------------
`include "proof_frame_parser_assert.svh"

module proof_frame_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  pfp_pkg::pfp_in_t  in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output pfp_pkg::pfp_out_t out_item_o
);
  import pfp_pkg::*;

  pfp_tok_t push_tok, pop_tok;
  logic     push_valid, q_full, q_valid, q_pop;
  logic     out_seq, out_err;

  // classification and checks
  pfp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .tok_valid_o (push_valid),
    .tok_full_i  (q_full),
    .tok_o       (push_tok)
  );

  // decoupling queue
  pfp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_valid),
    .data_i  (push_tok),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (pop_tok)
  );

  // word assembly and output register
  pfp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (q_valid),
    .tok_i       (pop_tok),
    .tok_pop_o   (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  // offered results by class
  assign out_seq = out_valid_o && (out_item_o.field_kind == KIND_SEQ);
  assign out_err = out_valid_o && (out_item_o.error_code != ERR_NONE);

  // the queue only fills up behind a held result
  `PFP_ASSERT(a_full_needs_held_out, in_stall_o |-> out_valid_o)
  // a completed sequence word is never zero
  `PFP_ASSERT(a_seq_nonzero, out_seq |-> out_item_o.word_value != 64'd0)
  // an error result carries no tag and no pass verdict
  `PFP_ASSERT(a_err_masks, out_err |-> out_item_o.field_kind == KIND_NONE && !out_item_o.frame_ok)
  // nothing is offered right after reset
  `PFP_ASSERT_NR(a_reset_quiet, !rst_ni |=> !out_valid_o)

endmodule

// ===== rtl/core/pfp_front.sv =====
// ----------------------------------------------------------------------------
// Proof frame parser front end
// Tracks the frame layout byte by byte, runs the header and name checks,
// latches the first error and tags each byte for the back end.
// ----------------------------------------------------------------------------
module pfp_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  pfp_pkg::pfp_in_t in_item_i,
  output logic             tok_valid_o,
  input  logic             tok_full_i,
  output pfp_pkg::pfp_tok_t tok_o
);
  import pfp_pkg::*;

  typedef enum logic [3:0] {
    PH_MAGIC,
    PH_VERSION,
    PH_CKPT,
    PH_TLEN,
    PH_TENANT,
    PH_PLEN,
    PH_PROVIDER,
    PH_SEQ,
    PH_HEAD,
    PH_PATH,
    PH_DONE
  } phase_e;

  phase_e           phase_q, phase_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [7:0]       hi_q, hi_d;
  logic [15:0]      name_len_q, name_len_d;
  logic             seq_nz_q, seq_nz_d;
  logic [3:0]       err_q, err_d;

  logic [7:0]  b;
  logic        eof;
  logic        push;
  logic [15:0] len_val;
  logic [15:0] limit;
  logic [3:0]  err_new;
  logic [2:0]  kind;
  logic        shift;

  assign b    = in_item_i.wire_byte;
  assign eof  = in_item_i.end_of_frame;
  assign push = in_valid_i && !tok_full_i;

  assign len_val = {hi_q, b};
  assign limit   = (phase_q == PH_TLEN) ? TENANT_LIMIT : PROVIDER_LIMIT;

  // per-byte phase walk and checks
  always_comb begin
    phase_d    = phase_q;
    cnt_d      = cnt_q;
    hi_d       = hi_q;
    name_len_d = name_len_q;
    seq_nz_d   = seq_nz_q;
    err_new    = ERR_NONE;
    kind       = KIND_NONE;
    shift      = 1'b0;
    if (err_q == ERR_NONE) begin
      unique case (phase_q)
        PH_MAGIC: begin
          if (b != magic_byte(cnt_q[2:0])) begin
            err_new = ERR_MAGIC;
          end else if (cnt_q == CNT_W'(7)) begin
            phase_d = PH_VERSION;
            cnt_d   = '0;
          end else begin
            cnt_d = cnt_q + CNT_W'(1);
          end
        end
        PH_VERSION: begin
          if (cnt_q == '0) begin
            hi_d  = b;
            cnt_d = CNT_W'(1);
          end else begin
            if (len_val != 16'd1) err_new = ERR_VERSION;
            else phase_d = PH_CKPT;
            cnt_d = '0;
          end
        end
        PH_CKPT: begin
          shift = 1'b1;
          if (cnt_q == CNT_W'(7)) begin
            kind    = KIND_CKPT;
            phase_d = PH_TLEN;
            cnt_d   = '0;
          end else begin
            cnt_d = cnt_q + CNT_W'(1);
          end
        end
        PH_TLEN, PH_PLEN: begin
          if (cnt_q == '0) begin
            hi_d  = b;
            cnt_d = CNT_W'(1);
          end else begin
            if (len_val == 16'd0 || len_val > limit) begin
              err_new = (phase_q == PH_TLEN) ? ERR_TENANT_LEN : ERR_PROVIDER_LEN;
            end else begin
              name_len_d = len_val;
              phase_d    = (phase_q == PH_TLEN) ? PH_TENANT : PH_PROVIDER;
            end
            cnt_d = '0;
          end
        end
        PH_TENANT, PH_PROVIDER: begin
          if (b == 8'd0) begin
            err_new = (phase_q == PH_TENANT) ? ERR_TENANT_ZERO : ERR_PROVIDER_ZERO;
          end else begin
            kind       = (phase_q == PH_TENANT) ? KIND_TENANT : KIND_PROVIDER;
            name_len_d = name_len_q - 16'd1;
            if (name_len_q == 16'd1) begin
              phase_d = (phase_q == PH_TENANT) ? PH_PLEN : PH_SEQ;
              cnt_d   = '0;
            end
          end
        end
        PH_SEQ: begin
          shift = 1'b1;
          if (cnt_q == CNT_W'(7)) begin
            if (!(seq_nz_q || (b != 8'd0))) begin
              err_new = ERR_SEQ_ZERO;
            end else begin
              kind    = KIND_SEQ;
              phase_d = PH_HEAD;
            end
            cnt_d    = '0;
            seq_nz_d = 1'b0;
          end else begin
            cnt_d    = cnt_q + CNT_W'(1);
            seq_nz_d = seq_nz_q || (b != 8'd0);
          end
        end
        PH_HEAD: begin
          kind = KIND_HEAD;
          if (cnt_q == CNT_W'(HASH_BYTES - 1)) begin
            phase_d = PH_PATH;
            cnt_d   = '0;
          end else begin
            cnt_d = cnt_q + CNT_W'(1);
          end
        end
        PH_PATH: begin
          kind = KIND_PATH;
          if (cnt_q == CNT_W'(PATH_BYTES - 1)) begin
            phase_d = PH_DONE;
            cnt_d   = '0;
          end else begin
            cnt_d = cnt_q + CNT_W'(1);
          end
        end
        default: begin
          err_new = ERR_TOO_LONG;
        end
      endcase
    end

    // first error wins; end of frame short of the last path byte is truncation
    err_d = (err_q != ERR_NONE) ? err_q : err_new;
    if (eof && err_d == ERR_NONE && phase_d != PH_DONE) err_d = ERR_TRUNCATED;
    if (err_d != ERR_NONE) begin
      kind  = KIND_NONE;
      shift = 1'b0;
    end
  end

  // tagged byte toward the queue
  assign tok_valid_o    = in_valid_i;
  assign in_stall_o     = tok_full_i;
  assign tok_o.wire_byte = b;
  assign tok_o.kind      = kind;
  assign tok_o.shift     = shift;
  assign tok_o.eof       = eof;
  assign tok_o.err       = err_d;

  // parse state; end of frame returns everything to the start
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_MAGIC;
      cnt_q      <= '0;
      hi_q       <= '0;
      name_len_q <= '0;
      seq_nz_q   <= 1'b0;
      err_q      <= ERR_NONE;
    end else if (push) begin
      if (eof) begin
        phase_q    <= PH_MAGIC;
        cnt_q      <= '0;
        hi_q       <= '0;
        name_len_q <= '0;
        seq_nz_q   <= 1'b0;
        err_q      <= ERR_NONE;
      end else begin
        phase_q    <= phase_d;
        cnt_q      <= cnt_d;
        hi_q       <= hi_d;
        name_len_q <= name_len_d;
        seq_nz_q   <= seq_nz_d;
        err_q      <= err_d;
      end
    end
  end

endmodule

// ===== rtl/core/pfp_fifo.sv =====
// ----------------------------------------------------------------------------
// Proof frame parser item queue
// Short register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module pfp_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  pfp_pkg::pfp_tok_t data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output pfp_pkg::pfp_tok_t data_o
);
  import pfp_pkg::*;

  pfp_tok_t          mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + QPTR_W'(1);
      end
      if (do_push && !do_pop) cnt_q <= cnt_q + QCNT_W'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - QCNT_W'(1);
    end
  end

endmodule

// ===== rtl/core/pfp_back.sv =====
// ----------------------------------------------------------------------------
// Proof frame parser back end
// Assembles the big-endian 64-bit words, formats each result item and holds
// it in the output register.
// ----------------------------------------------------------------------------
module pfp_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              tok_valid_i,
  input  pfp_pkg::pfp_tok_t tok_i,
  output logic              tok_pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output pfp_pkg::pfp_out_t out_item_o
);
  import pfp_pkg::*;

  logic [55:0] acc_q, acc_d;
  logic        out_valid_q;
  pfp_out_t    out_q, out_d;
  logic        pop;
  logic        word_done;
  logic        byte_kind;
  logic [63:0] word_full;

  assign pop       = tok_valid_i && (!out_valid_q || !out_stall_i);
  assign tok_pop_o = pop;

  assign word_full = {acc_q, tok_i.wire_byte};
  assign word_done = (tok_i.kind == KIND_CKPT) || (tok_i.kind == KIND_SEQ);
  assign byte_kind = (tok_i.kind == KIND_TENANT) || (tok_i.kind == KIND_PROVIDER) ||
                     (tok_i.kind == KIND_HEAD) || (tok_i.kind == KIND_PATH);

  // word assembly: cleared when a word completes or the frame ends
  always_comb begin
    acc_d = acc_q;
    if (tok_i.eof || word_done) acc_d = '0;
    else if (tok_i.shift) acc_d = word_full[55:0];
  end

  // result formatting
  always_comb begin
    out_d.field_kind = tok_i.kind;
    out_d.byte_value = byte_kind ? tok_i.wire_byte : 8'd0;
    out_d.word_value = word_done ? word_full : 64'd0;
    out_d.frame_done = tok_i.eof;
    out_d.frame_ok   = tok_i.eof && (tok_i.err == ERR_NONE);
    out_d.error_code = tok_i.err;
  end

  // control state and accumulator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      acc_q       <= '0;
    end else begin
      if (pop) begin
        out_valid_q <= 1'b1;
        acc_q       <= acc_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (pop) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
